@@ src/nbb_pkg.sv @@
// ----------------------------------------------------------------------------
// nbb_pkg: shared definitions for the noise bandpass biquad
// Widths, register indexes, sequencer states and the control bundle that
// drives the shared multiply and round unit.
// ----------------------------------------------------------------------------
package nbb_pkg;

    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int COEFF_FRAC_BITS_DEF = 30;

    localparam int COEF_W  = 32;              // widest coefficient operand
    localparam int STATE_W = 40;              // delay line word
    localparam int SPLIT_W = 20;              // low half of a split state word
    localparam int FULL_W  = COEF_W + STATE_W; // full coefficient x state product
    localparam int FX_W    = 32;              // b0 * x after rounding

    localparam int B0_W   = 30;
    localparam int A1_W   = 32;
    localparam int A2_W   = 31;
    localparam int GAIN_W = 29;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORWARD,
        CFG_FEEDBACK_ONE,
        CFG_FEEDBACK_TWO,
        CFG_GAIN
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FX,
        ST_V,
        ST_M1L,
        ST_M1H,
        ST_M2L,
        ST_M2H,
        ST_GL,
        ST_GH,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        COEF_B0,
        COEF_A1,
        COEF_A2,
        COEF_GAIN
    } coef_sel_t;

    typedef enum logic [1:0] {
        DATA_X,
        DATA_VLO,
        DATA_VHI
    } data_sel_t;

    typedef struct packed {
        logic      issue;
        coef_sel_t coef_sel;
        data_sel_t data_sel;
        logic      lo_load;
        logic      v_load;
        logic      d1_load;
        logic      d2_load;
        logic      out_load;
    } seq_ctrl_t;

endpackage

@@ src/noise_bandpass_biquad.sv @@
// ----------------------------------------------------------------------------
// noise_bandpass_biquad: constant-skirt bandpass biquad with output gain
// Transposed direct form II filter (b2 = -b0) on a noise excitation stream,
// followed by a gain stage with full-scale saturation and a bound fault flag.
// ----------------------------------------------------------------------------
// A sample is accepted only in the idle state, so a new one is not taken
// before the previous result is loaded into the output register; it is
// taken in the cycle after that load, even while the previous result still
// waits on m_ready. The steps follow the single shared multiplier: b0*x
// takes one pass, v is then formed from it, and each of a1*v, a2*v and
// gain*v takes two passes over the low and high halves of the 40-bit
// state word; the gained output is rounded and saturated as it is loaded.
// If the output register is still full when a result is ready, the
// sequencer holds until it drains. Coefficients are Q2.30 and may be
// written through the cfg_wr_* port while no sample is in flight.
// ----------------------------------------------------------------------------
module noise_bandpass_biquad #(
    parameter int SAMPLE_BITS     = nbb_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_FRAC_BITS = nbb_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_wr_en,
    input  logic [nbb_pkg::CFG_IDX_W-1:0]         cfg_wr_index,
    input  logic [nbb_pkg::CFG_DATA_W-1:0]        cfg_wr_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [SAMPLE_BITS-1:0]         s_excitation_sample,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [SAMPLE_BITS-1:0]         m_filtered_sample,
    output logic                                  m_bound_fault
);
    import nbb_pkg::*;

    localparam int OPB_W = (SAMPLE_BITS > SPLIT_W) ? SAMPLE_BITS : SPLIT_W + 1;
    localparam int M_W   = FULL_W - COEFF_FRAC_BITS;
    localparam int SUM_W = M_W + 1;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - STATE_W + 1){1'b0}}, {(STATE_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    localparam logic signed [M_W-1:0] ONE_S     = M_W'(1) <<< COEFF_FRAC_BITS;
    localparam logic signed [M_W-1:0] NEG_ONE_S = -ONE_S;

    // alignment of the Q2.C gained value to the Q1.(SAMPLE_BITS-1) output
    localparam int SH   = COEFF_FRAC_BITS - (SAMPLE_BITS - 1);
    localparam int RSH  = (SH > 0) ? SH : 1;
    localparam int LSH  = (SH < 0) ? -SH : 0;
    localparam int SS_W = COEFF_FRAC_BITS + 2;
    localparam int RS_W = COEFF_FRAC_BITS + 3;
    localparam int YW   = SAMPLE_BITS + 1;

    localparam logic signed [RS_W-1:0] HALF_R = RS_W'(1) <<< (RSH - 1);

    localparam logic [SAMPLE_BITS-1:0] FS_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] FS_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // configuration
    logic [B0_W-1:0]          forward_coeff_reg;
    logic signed [A1_W-1:0]   feedback_coeff_one_reg;
    logic signed [A2_W-1:0]   feedback_coeff_two_reg;
    logic [GAIN_W-1:0]        output_gain_reg;

    // sequencer and datapath
    state_t                   state_reg, state_next;
    seq_ctrl_t                ctrl;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [FX_W-1:0]   fx_reg;
    logic signed [STATE_W-1:0] v_reg, v_next;
    logic signed [STATE_W-1:0] delay_one_reg, delay_one_next;
    logic signed [STATE_W-1:0] delay_two_reg, delay_two_next;

    logic signed [COEF_W-1:0] coef_op;
    logic signed [OPB_W-1:0]  data_op;
    logic signed [FX_W-1:0]   fx_out;
    logic signed [M_W-1:0]    prod_out;

    // output stage
    logic                     out_free;
    logic                     m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0]   filtered_sample_reg, filtered_sample_next;
    logic                     bound_fault_reg, bound_fault_next;

    logic                     fault;
    logic signed [SS_W-1:0]   s_small;
    logic signed [RS_W-1:0]   r_sum;
    logic signed [RS_W-1:0]   r_shr;
    logic signed [YW-1:0]     y_wide;
    logic [SAMPLE_BITS-1:0]   y_clamp;

    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [SUM_W-1:0] a
    );
        logic signed [STATE_W-1:0] r;
        priority if (a > SAT_HI) begin
            r = SAT_HI[STATE_W-1:0];
        end else if (a < SAT_LO) begin
            r = SAT_LO[STATE_W-1:0];
        end else begin
            r = a[STATE_W-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            forward_coeff_reg      <= '0;
            feedback_coeff_one_reg <= '0;
            feedback_coeff_two_reg <= '0;
            output_gain_reg        <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_index))
                CFG_FORWARD:      forward_coeff_reg      <= cfg_wr_data[B0_W-1:0];
                CFG_FEEDBACK_ONE: feedback_coeff_one_reg <= cfg_wr_data[A1_W-1:0];
                CFG_FEEDBACK_TWO: feedback_coeff_two_reg <= cfg_wr_data[A2_W-1:0];
                CFG_GAIN:         output_gain_reg        <= cfg_wr_data[GAIN_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_FX;
                end
            end
            ST_FX:  state_next = ST_V;
            ST_V:   state_next = ST_M1L;
            ST_M1L: state_next = ST_M1H;
            ST_M1H: state_next = ST_M2L;
            ST_M2L: state_next = ST_M2H;
            ST_M2H: state_next = ST_GL;
            ST_GL:  state_next = ST_GH;
            ST_GH:  state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '{issue: 1'b0, coef_sel: COEF_B0, data_sel: DATA_X, lo_load: 1'b0,
                 v_load: 1'b0, d1_load: 1'b0, d2_load: 1'b0, out_load: 1'b0};
        unique case (state_reg)
            ST_IDLE: ;
            ST_FX: begin
                ctrl.issue = 1'b1;
            end
            ST_V: begin
                ctrl.v_load = 1'b1;
            end
            ST_M1L: begin
                ctrl.issue    = 1'b1;
                ctrl.coef_sel = COEF_A1;
                ctrl.data_sel = DATA_VLO;
            end
            ST_M1H: begin
                ctrl.issue    = 1'b1;
                ctrl.coef_sel = COEF_A1;
                ctrl.data_sel = DATA_VHI;
                ctrl.lo_load  = 1'b1;
            end
            ST_M2L: begin
                ctrl.issue    = 1'b1;
                ctrl.coef_sel = COEF_A2;
                ctrl.data_sel = DATA_VLO;
                ctrl.d1_load  = 1'b1;
            end
            ST_M2H: begin
                ctrl.issue    = 1'b1;
                ctrl.coef_sel = COEF_A2;
                ctrl.data_sel = DATA_VHI;
                ctrl.lo_load  = 1'b1;
            end
            ST_GL: begin
                ctrl.issue    = 1'b1;
                ctrl.coef_sel = COEF_GAIN;
                ctrl.data_sel = DATA_VLO;
                ctrl.d2_load  = 1'b1;
            end
            ST_GH: begin
                ctrl.issue    = 1'b1;
                ctrl.coef_sel = COEF_GAIN;
                ctrl.data_sel = DATA_VHI;
                ctrl.lo_load  = 1'b1;
            end
            ST_OUT: begin
                ctrl.out_load = out_free;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Operand selection and shared multiplier
    // ------------------------------------------------------------------
    always_comb begin
        unique case (ctrl.coef_sel)
            COEF_B0:   coef_op = COEF_W'($signed({1'b0, forward_coeff_reg}));
            COEF_A1:   coef_op = COEF_W'(feedback_coeff_one_reg);
            COEF_A2:   coef_op = COEF_W'(feedback_coeff_two_reg);
            COEF_GAIN: coef_op = COEF_W'($signed({1'b0, output_gain_reg}));
        endcase
    end

    always_comb begin
        unique case (ctrl.data_sel)
            DATA_X:   data_op = OPB_W'(x_reg);
            DATA_VLO: data_op = OPB_W'($signed({1'b0, v_reg[SPLIT_W-1:0]}));
            DATA_VHI: data_op = OPB_W'($signed(v_reg[STATE_W-1:SPLIT_W]));
            default:  data_op = '0;
        endcase
    end

    nbb_mul_unit #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_mul (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .coef_op  (coef_op),
        .data_op  (data_op),
        .fx_out   (fx_out),
        .prod_out (prod_out)
    );

    // ------------------------------------------------------------------
    // Filter state
    // ------------------------------------------------------------------
    always_comb begin
        v_next         = sat_state(SUM_W'(fx_out) + SUM_W'(delay_one_reg));
        delay_one_next = delay_one_reg;
        delay_two_next = delay_two_reg;
        // prod_out holds a1*v here; delay_two is still the old value
        if (ctrl.d1_load) begin
            delay_one_next = sat_state(SUM_W'(delay_two_reg) - SUM_W'(prod_out));
        end
        // the b2 term is the b0 product negated
        if (ctrl.d2_load) begin
            delay_two_next = sat_state(-SUM_W'(fx_reg) - SUM_W'(prod_out));
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg <= s_excitation_sample;
        end
        if (ctrl.v_load) begin
            v_reg  <= v_next;
            fx_reg <= fx_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            delay_one_reg <= '0;
            delay_two_reg <= '0;
        end else begin
            state_reg     <= state_next;
            delay_one_reg <= delay_one_next;
            delay_two_reg <= delay_two_next;
        end
    end

    // ------------------------------------------------------------------
    // Gained output: bound check, alignment and saturation
    // ------------------------------------------------------------------
    always_comb begin
        fault   = (prod_out >= ONE_S) || (prod_out <= NEG_ONE_S);
        // below 1.0 in magnitude the value fits in C+2 bits
        s_small = prod_out[SS_W-1:0];
        r_sum   = RS_W'(s_small) + HALF_R;
        r_shr   = r_sum >>> RSH;
        if (SH > 0) begin
            y_wide = YW'(r_shr);
        end else begin
            y_wide = YW'(s_small) <<< LSH;
        end
        if (y_wide[YW-1] != y_wide[YW-2]) begin
            y_clamp = y_wide[YW-1] ? FS_MIN : FS_MAX;
        end else begin
            y_clamp = y_wide[SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        m_valid_next         = m_valid_reg && !m_ready;
        filtered_sample_next = filtered_sample_reg;
        bound_fault_next     = bound_fault_reg;
        if (ctrl.out_load) begin
            m_valid_next         = 1'b1;
            bound_fault_next     = fault;
            filtered_sample_next = fault ? (prod_out[M_W-1] ? FS_MIN : FS_MAX) : y_clamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        filtered_sample_reg <= filtered_sample_next;
        bound_fault_reg     <= bound_fault_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_filtered_sample = filtered_sample_reg;
    assign m_bound_fault     = bound_fault_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    ap_idle_state_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |=> ($stable(delay_one_reg) && $stable(delay_two_reg)))
        else $error("filter state changed while no sample was in flight");

    ap_result_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output step");

    ap_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_load |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

    ap_fault_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && bound_fault_reg) |->
            (filtered_sample_reg == FS_MAX || filtered_sample_reg == FS_MIN))
        else $error("bound fault without full-scale output");

endmodule

@@ src/nbb_mul_unit.sv @@
// ----------------------------------------------------------------------------
// nbb_mul_unit: shared multiplier with rounding
// One registered signed multiply per cycle while ctrl.issue is set. A
// coefficient times a 40-bit state word is formed from two passes (low and
// high 20-bit halves) that are recombined and rounded to the state format.
// ----------------------------------------------------------------------------
module nbb_mul_unit #(
    parameter int   SAMPLE_BITS     = nbb_pkg::SAMPLE_BITS_DEF,
    parameter int   COEFF_FRAC_BITS = nbb_pkg::COEFF_FRAC_BITS_DEF,
    localparam int  OPB_W = (SAMPLE_BITS > nbb_pkg::SPLIT_W) ? SAMPLE_BITS
                                                             : nbb_pkg::SPLIT_W + 1,
    localparam int  M_W   = nbb_pkg::FULL_W - COEFF_FRAC_BITS
) (
    input  logic                                aclk,
    input  nbb_pkg::seq_ctrl_t                  ctrl,
    input  logic signed [nbb_pkg::COEF_W-1:0]   coef_op,
    input  logic signed [OPB_W-1:0]             data_op,
    output logic signed [nbb_pkg::FX_W-1:0]     fx_out,
    output logic signed [M_W-1:0]               prod_out
);
    import nbb_pkg::*;

    localparam int PROD_W = COEF_W + OPB_W;
    localparam int LO_W   = COEF_W + SPLIT_W + 1;
    localparam int FXS_W  = PROD_W + 1;

    localparam logic signed [FXS_W-1:0]  HALF_X = FXS_W'(1) <<< (SAMPLE_BITS - 2);
    localparam logic signed [FULL_W-1:0] HALF_C = FULL_W'(1) <<< (COEFF_FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [LO_W-1:0]   lo_reg;
    logic signed [FXS_W-1:0]  fx_sum;
    logic signed [FXS_W-1:0]  fx_shr;
    logic signed [FULL_W-1:0] full_sum;
    logic signed [FULL_W-1:0] full_shr;

    always_ff @(posedge aclk) begin
        if (ctrl.issue) begin
            prod_reg <= coef_op * data_op;
        end
        // keep the low-half product while the high half is formed
        if (ctrl.lo_load) begin
            lo_reg <= prod_reg[LO_W-1:0];
        end
    end

    always_comb begin
        fx_sum   = FXS_W'(prod_reg) + HALF_X;
        fx_shr   = fx_sum >>> (SAMPLE_BITS - 1);
        full_sum = (FULL_W'(prod_reg) <<< SPLIT_W) + FULL_W'(lo_reg) + HALF_C;
        full_shr = full_sum >>> COEFF_FRAC_BITS;
    end

    assign fx_out   = fx_shr[FX_W-1:0];
    assign prod_out = full_shr[M_W-1:0];

endmodule

@@ tb/noise_bandpass_biquad_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_bandpass_biquad_tb: self-checking bench for the bandpass biquad
// Streams excitation samples through the filter while both sides idle and
// stall at random. A bit-exact software copy of the filter, gain and bound
// stages predicts every output. Coefficient settings change between phases
// and include stable bandpass, raw random and extreme unstable cases.
// ----------------------------------------------------------------------------
module noise_bandpass_biquad_tb;
    import nbb_pkg::*;

    localparam int SAMPLE_W        = SAMPLE_BITS_DEF;
    localparam int FRAC_IN         = SAMPLE_W - 1;
    localparam int FRAC_COEF       = COEFF_FRAC_BITS_DEF;
    localparam int STALL_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_BATCH = 160;

    typedef logic signed [95:0]         acc_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t sample;
        logic    fault;
    } biquad_out_t;

    localparam acc_t STATE_MAX = (acc_t'(1) <<< (STATE_W - 1)) - 1;
    localparam acc_t STATE_MIN = -(acc_t'(1) <<< (STATE_W - 1));
    localparam acc_t UNITY     = acc_t'(1) <<< FRAC_COEF;
    localparam acc_t OUT_MAX   = (acc_t'(1) <<< FRAC_IN) - 1;
    localparam acc_t OUT_MIN   = -(acc_t'(1) <<< FRAC_IN);

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    sample_t               s_excitation_sample = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    sample_t               m_filtered_sample;
    logic                  m_bound_fault;

    // register mirror and delay line of the prediction
    logic [B0_W-1:0]          b0_reg = '0;
    logic signed [A1_W-1:0]   a1_reg = '0;
    logic signed [A2_W-1:0]   a2_reg = '0;
    logic [GAIN_W-1:0]        gain_reg = '0;
    acc_t                     z1_state = '0;
    acc_t                     z2_state = '0;

    sample_t     pending_samples[$];
    biquad_out_t expected_out[$];

    int   sender_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   queued_count = 0;
    int   accepted_count = 0;
    int   result_count = 0;
    int   fault_count = 0;
    int   cfg_write_count = 0;
    int   error_count = 0;
    int   idle_cycles = 0;
    logic in_fire = 1'b0;

    noise_bandpass_biquad u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_index        (cfg_wr_index),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_excitation_sample (s_excitation_sample),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_filtered_sample   (m_filtered_sample),
        .m_bound_fault       (m_bound_fault)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // add half an LSB, then floor
    function automatic acc_t round_shift_q(acc_t p, int n);
        return (p + (acc_t'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic acc_t clamp_q(acc_t p, acc_t lo, acc_t hi);
        return (p > hi) ? hi : ((p < lo) ? lo : p);
    endfunction

    function automatic biquad_out_t filter_sample(sample_t x);
        acc_t        xs, b0, a1, a2, g;
        acc_t        fx, v, s, y, next_z1, next_z2;
        biquad_out_t r;
        xs = x;
        b0 = b0_reg;
        a1 = a1_reg;
        a2 = a2_reg;
        g  = gain_reg;
        fx = round_shift_q(b0 * xs, FRAC_IN);
        v  = clamp_q(fx + z1_state, STATE_MIN, STATE_MAX);
        next_z1 = clamp_q(-round_shift_q(a1 * v, FRAC_COEF) + z2_state, STATE_MIN, STATE_MAX);
        // b2 = -b0: reuse the b0 product
        next_z2 = clamp_q(-fx - round_shift_q(a2 * v, FRAC_COEF), STATE_MIN, STATE_MAX);
        z1_state = next_z1;
        z2_state = next_z2;
        s = round_shift_q(g * v, FRAC_COEF);
        r.fault = (s >= UNITY) || (s <= -UNITY);
        if (r.fault) begin
            y = (s > 0) ? OUT_MAX : OUT_MIN;
        end else begin
            y = clamp_q(round_shift_q(s, FRAC_COEF - FRAC_IN), OUT_MIN, OUT_MAX);
        end
        r.sample = y[SAMPLE_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $time, msg);
        error_count++;
    endtask

    // call at a falling edge; the block is idle
    task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = data;
        case (idx)
            CFG_FORWARD:      b0_reg   = data[B0_W-1:0];
            CFG_FEEDBACK_ONE: a1_reg   = data[A1_W-1:0];
            CFG_FEEDBACK_TWO: a2_reg   = data[A2_W-1:0];
            CFG_GAIN:         gain_reg = data[GAIN_W-1:0];
            default: ;
        endcase
        cfg_write_count++;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic queue_sample(sample_t x);
        pending_samples.push_back(x);
        queued_count++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (accepted_count != queued_count || expected_out.size() != 0);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin sender_idle_pct = 12; recv_stall_pct = 12; end
        endcase
    endtask

    function automatic sample_t random_excitation();
        logic [31:0] bits;
        sample_t     x;
        bits = $urandom;
        x = bits[SAMPLE_W-1:0];
        // mostly quieter samples, some full scale
        if ($urandom_range(3) != 0)
            x = x >>> $urandom_range(12);
        return x;
    endfunction

    task automatic program_setting(int kind);
        longint a1v, a2v, lim;
        case (kind)
            0: begin
                // stable resonator: inside the stability triangle with margin
                a2v = $urandom_range(1063004405, 536870912);
                lim = (longint'(1) << FRAC_COEF) + a2v - (longint'(1) << 24);
                a1v = longint'($urandom_range(32'(2 * lim))) - lim;
                cfg_write(CFG_FORWARD, $urandom_range(1 << 28));
                cfg_write(CFG_FEEDBACK_ONE, a1v[31:0]);
                cfg_write(CFG_FEEDBACK_TWO, a2v[31:0]);
                cfg_write(CFG_GAIN, $urandom_range(1 << 28, 1 << 26));
            end
            1: begin
                // raw random words, unused upper bits included
                cfg_write(CFG_FORWARD, $urandom);
                cfg_write(CFG_FEEDBACK_ONE, $urandom);
                cfg_write(CFG_FEEDBACK_TWO, $urandom);
                cfg_write(CFG_GAIN, $urandom);
            end
            default: begin
                cfg_write(CFG_FORWARD, 32'hFFFF_FFFF);
                cfg_write(CFG_FEEDBACK_ONE, $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000);
                cfg_write(CFG_FEEDBACK_TWO, $urandom_range(1) ? 32'h3FFF_FFFF : 32'h4000_0000);
                cfg_write(CFG_GAIN, $urandom_range(1) ? 32'h1000_0000 : 32'hFFFF_FFFF);
            end
        endcase
    endtask

    // driver: hold a presented transaction until it is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_valid             <= 1'b1;
                s_excitation_sample <= pending_samples.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: check outputs first, then predict the incoming transaction
    always @(posedge aclk) begin
        biquad_out_t want;
        if (!aresetn) begin
            idle_cycles = 0;
            in_fire <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_out.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none pending",
                                              result_count));
                end else begin
                    want = expected_out.pop_front();
                    if (m_filtered_sample !== want.sample)
                        report_mismatch($sformatf("result %0d sample %0d, want %0d",
                                                  result_count, m_filtered_sample,
                                                  want.sample));
                    if (m_bound_fault !== want.fault)
                        report_mismatch($sformatf("result %0d fault %b, want %b",
                                                  result_count, m_bound_fault,
                                                  want.fault));
                end
            end
            if (s_valid && s_ready) begin
                want = filter_sample(s_excitation_sample);
                if (want.fault)
                    fault_count++;
                expected_out.push_back(want);
                accepted_count++;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            in_fire <= s_valid && s_ready;
        end
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT)
            @(negedge aclk);
        $display("stalled for %0d cycles", STALL_LIMIT);
        $display("noise_bandpass_biquad_tb: errors");
        $finish;
    end

    initial begin : stimulus
        int p;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // registers still at reset: silent output
        set_idling(0);
        queue_sample(sample_t'(OUT_MAX));
        queue_sample(sample_t'(OUT_MIN));
        wait_drained();

        // zeros only, b0 at its top code with the unused bits set, quarter gain
        cfg_write(CFG_FORWARD, 32'hFFFF_FFFF);
        cfg_write(CFG_FEEDBACK_ONE, 32'h0);
        cfg_write(CFG_FEEDBACK_TWO, 32'h0);
        cfg_write(CFG_GAIN, 32'h1000_0000);
        queue_sample(sample_t'(OUT_MAX));
        queue_sample(sample_t'(OUT_MIN));
        queue_sample(24'sh000000);
        queue_sample(24'sh000001);
        queue_sample(-24'sh000001);
        queue_sample(24'sh555555);
        queue_sample(24'shAAAAAA);
        wait_drained();

        // divergent poles, top gain: faults and a saturated delay line
        cfg_write(CFG_FEEDBACK_ONE, 32'h8000_0000);
        cfg_write(CFG_FEEDBACK_TWO, 32'h4000_0000);
        cfg_write(CFG_GAIN, 32'hFFFF_FFFF);
        repeat (8) queue_sample(sample_t'(OUT_MIN));
        repeat (8) queue_sample(sample_t'(OUT_MAX));
        wait_drained();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            set_idling(p % 4);
            program_setting(p % 3);
            repeat (ITEMS_PER_BATCH) queue_sample(random_excitation());
            // hold off the second batch until the first has fully drained
            wait_drained();
            repeat (ITEMS_PER_BATCH) queue_sample(random_excitation());
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("summary: %0d samples filtered, %0d outputs hit the bound, %0d register writes",
                 result_count, fault_count, cfg_write_count);
        $display("summary: %0d mismatches over %0d setting phases",
                 error_count, RANDOM_PHASES + 3);
        if (error_count == 0 && expected_out.size() == 0) begin
            $display("noise_bandpass_biquad_tb: clean");
        end else begin
            $display("noise_bandpass_biquad_tb: errors");
        end
        $finish;
    end

endmodule
